// ===== src/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Shared types and constants for the sequencer datapath and its top level.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int unsigned TenthsWidth   = 8;
   localparam int unsigned TicksWidth    = 16;
   localparam int unsigned PeriodWidth   = 24;
   localparam int unsigned CountWidth    = 26;
   localparam int unsigned BeepWidth     = 8;
   localparam int unsigned GroupWidth    = 8;

   localparam logic [TicksWidth-1:0] TicksPerTenthReset = 16'd100;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_TO_ON    = 3'd1,
      PH_ON       = 3'd2,
      PH_TO_OFF   = 3'd3,
      PH_OFF      = 3'd4,
      PH_TO_DELAY = 3'd5,
      PH_DELAY    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [1:0]             operation;
      logic [BeepWidth-1:0]   beeps_per_group;
      logic [TenthsWidth-1:0] beep_tenths;
      logic [GroupWidth-1:0]  group_count;
   } req_item_type;

   typedef struct packed {
      logic buzzer_level;
      logic busy_res;
   } rsp_item_type;

endpackage

// ===== src/bps_seq.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer step logic
// Holds the pattern state and the tick scale register, and applies one
// request per enabled cycle, giving the result of that step.
// ----------------------------------------------------------------------------
module bps_seq
   import bps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [TicksWidth-1:0] csr_wr_data,
   input  logic                  step_en,
   input  req_item_type          item,
   output rsp_item_type          result
);

   logic [TicksWidth-1:0]  tpt_ff;
   phase_type              phase_ff, phase_in;
   logic [BeepWidth-1:0]   beeps_left_ff, beeps_left_in;
   logic [BeepWidth-1:0]   beeps_reload_ff, beeps_reload_in;
   logic [GroupWidth-1:0]  groups_left_ff, groups_left_in;
   logic [PeriodWidth-1:0] period_ff, period_in;
   logic [CountWidth-1:0]  remain_ff, remain_in;
   logic                   level_ff, level_in;

   logic [CountWidth-1:0]  period_ext;
   logic [CountWidth-1:0]  silence;
   logic [BeepWidth-1:0]   beeps_eff;
   logic [GroupWidth-1:0]  groups_dec;

   assign period_ext = {2'b00, period_ff};
   // Three periods as a shift and an add.
   assign silence    = period_ext + {1'b0, period_ff, 1'b0};
   assign beeps_eff  = (item.beeps_per_group == '0) ? BeepWidth'(1) : item.beeps_per_group;
   assign groups_dec = groups_left_ff - GroupWidth'(1);

   always_comb begin
      phase_in        = phase_ff;
      beeps_left_in   = beeps_left_ff;
      beeps_reload_in = beeps_reload_ff;
      groups_left_in  = groups_left_ff;
      period_in       = period_ff;
      remain_in       = remain_ff;
      level_in        = level_ff;

      case (item.operation)
         OP_TICK: begin
            if (remain_ff != '0) begin
               remain_in = remain_ff - CountWidth'(1);
            end
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_ON: begin
                  if (remain_in == '0) begin
                     phase_in = PH_TO_OFF;
                  end
               end
               PH_TO_OFF: begin
                  beeps_left_in = beeps_left_ff - BeepWidth'(1);
                  level_in      = 1'b0;
                  remain_in     = period_ext;
                  phase_in      = PH_OFF;
               end
               PH_OFF: begin
                  if (remain_in == '0) begin
                     if (beeps_left_ff == '0) begin
                        groups_left_in = groups_dec;
                        if (groups_dec == '0) begin
                           phase_in = PH_IDLE;
                           level_in = 1'b0;
                        end else begin
                           phase_in = PH_TO_DELAY;
                        end
                     end else begin
                        phase_in = PH_TO_ON;
                     end
                  end
               end
               PH_TO_ON: begin
                  level_in  = 1'b1;
                  remain_in = period_ext;
                  phase_in  = PH_ON;
               end
               PH_TO_DELAY: begin
                  level_in  = 1'b0;
                  remain_in = silence;
                  phase_in  = PH_DELAY;
               end
               PH_DELAY: begin
                  if (remain_in == '0) begin
                     beeps_left_in = beeps_reload_ff;
                     remain_in     = period_ext;
                     level_in      = 1'b1;
                     phase_in      = PH_ON;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  level_in = 1'b0;
               end
            endcase
         end
         OP_START: begin
            if (item.group_count == '0) begin
               phase_in = PH_IDLE;
               level_in = 1'b0;
            end else begin
               beeps_left_in   = beeps_eff;
               beeps_reload_in = beeps_eff;
               period_in       = {{(PeriodWidth-TenthsWidth){1'b0}}, item.beep_tenths}
                               * {{(PeriodWidth-TicksWidth){1'b0}}, tpt_ff};
               groups_left_in  = item.group_count;
               phase_in        = PH_TO_ON;
            end
         end
         OP_STOP: begin
            phase_in = PH_IDLE;
            level_in = 1'b0;
         end
         default: begin
         end
      endcase

      if (phase_in == PH_IDLE) begin
         level_in = 1'b0;
      end
   end

   assign result.buzzer_level = level_in;
   assign result.busy_res     = (phase_in != PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         tpt_ff          <= TicksPerTenthReset;
         phase_ff        <= PH_IDLE;
         beeps_left_ff   <= '0;
         beeps_reload_ff <= '0;
         groups_left_ff  <= '0;
         period_ff       <= '0;
         remain_ff       <= '0;
         level_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tpt_ff <= csr_wr_data;
         end
         if (step_en) begin
            phase_ff        <= phase_in;
            beeps_left_ff   <= beeps_left_in;
            beeps_reload_ff <= beeps_reload_in;
            groups_left_ff  <= groups_left_in;
            period_ff       <= period_in;
            remain_ff       <= remain_in;
            level_ff        <= level_in;
         end
      end
   end

   // The buzzer is never driven while the sequencer is idle.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> !level_ff)
      else $error("buzzer driven while idle");

   // A running pattern always has at least one group still due.
   a_groups_due: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (groups_left_ff != '0))
      else $error("pattern running with no groups left");

   // A running pattern always reloads at least one beep per group.
   a_reload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (beeps_reload_ff != '0))
      else $error("pattern running with an empty beep reload");

endmodule

// ===== src/buzzer_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer
// Streams tick, start and stop requests through the beep-group sequencer.
// ----------------------------------------------------------------------------
// An accepted request sits in the input register; its step lands in the result
// register once that register is empty or being drained.
// Throughput: one request per clock while the result channel is not stalled.
// Reset: synchronous, active high; the sequencer goes idle with the buzzer
// low, ticks_per_tenth returns to 100 and both pipeline registers empty.
module buzzer_pattern_sequencer
   import bps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration: ticks_per_tenth.
   input  logic                  csr_wr_en,
   input  logic [TicksWidth-1:0] csr_wr_data,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: [7:0] beeps_per_group, [15:8] beep_tenths, [23:16] group_count.
   input  logic [23:0]           req_tdata,
   // tuser: [1:0] operation.
   input  logic [1:0]            req_tuser,
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: [0] buzzer_level, [1] busy_res, [7:2] zero.
   output logic [7:0]            rsp_tdata
);

   // Input register: holds one accepted request until the step logic can
   // hand its result to the result register.
   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   rsp_item_type  out_item_ff;
   rsp_item_type  step_result;
   logic          advance;
   logic          fire;

   // The step may run whenever the result register is empty or being drained.
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.operation       <= req_tuser;
         in_item_ff.beeps_per_group <= req_tdata[7:0];
         in_item_ff.beep_tenths     <= req_tdata[15:8];
         in_item_ff.group_count     <= req_tdata[23:16];
      end
      if (fire) begin
         out_item_ff <= step_result;
      end
   end

   // The sequencer state advances only when a request actually moves into
   // the result register, so a stalled request is applied exactly once.
   bps_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (fire),
      .item        (in_item_ff),
      .result      (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_item_ff.busy_res, out_item_ff.buzzer_level};

   // A stalled request waits in the input register.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled request dropped");

   // Every step applied lands in the result register.
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("step result lost");

   // An idle result never reports a sounding buzzer.
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_item_ff.busy_res) |-> !out_item_ff.buzzer_level)
      else $error("buzzer sounding in idle result");

endmodule
